@@ hw/rtl/pps_pkg.sv @@
// Shared types, register indexes and reset constants for the pressurisation phase sequencer.
package pps_pkg;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 104;
   localparam int unsigned RspDataWidth = 24;

   localparam logic [6:0] DrivePctMax = 7'd100;

   localparam logic [15:0]        ChamberCriticalReset    = 16'd20000;
   localparam logic [15:0]        InterstageCriticalReset = 16'd17000;
   localparam logic [15:0]        RestartPressureReset    = 16'd1000;
   localparam logic [15:0]        StableDeltaReset        = 16'd1;
   localparam logic [31:0]        StableWindowReset       = 32'd10000;
   localparam logic signed [15:0] OverTempReset           = 16'sd6000;
   localparam logic signed [15:0] ResumeTempReset         = 16'sd5000;
   localparam logic [6:0]         DrivePctReset           = 7'd100;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_CHAMBER_CRITICAL    = 3'd0,
      CSR_INTERSTAGE_CRITICAL = 3'd1,
      CSR_RESTART_PRESSURE    = 3'd2,
      CSR_STABLE_DELTA        = 3'd3,
      CSR_STABLE_WINDOW_MS    = 3'd4,
      CSR_OVER_TEMP           = 3'd5,
      CSR_RESUME_TEMP         = 3'd6,
      CSR_DRIVE_PCT           = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_FILLING   = 2'd0,
      PHASE_WAIT_DROP = 2'd1,
      PHASE_TEMP_HOLD = 2'd2,
      PHASE_FINISHED  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [15:0]        chamber_critical;
      logic [15:0]        interstage_critical;
      logic [15:0]        restart_pressure;
      logic [15:0]        stable_delta;
      logic [31:0]        stable_window_ms;
      logic signed [15:0] over_temp;
      logic signed [15:0] resume_temp;
      logic [6:0]         drive_pct;
   } cfg_type;

   typedef struct packed {
      logic               safety_stop;
      logic signed [15:0] temp_second;
      logic signed [15:0] temp_first;
      logic [15:0]        interstage_pressure;
      logic [15:0]        chamber_pressure;
      logic [31:0]        now_ms;
   } sample_type;

   typedef struct packed {
      logic [1:0] phase_now;
      logic       finished;
      logic       solenoid_open;
      logic [6:0] piston_pct;
      logic [6:0] diaphragm_pct;
   } result_type;

endpackage

@@ hw/rtl/pps_csr.sv @@
// Configuration registers of the pressurisation phase sequencer.
module pps_csr
   import pps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CHAMBER_CRITICAL:    cfg_in.chamber_critical    = csr_wdata[15:0];
            CSR_INTERSTAGE_CRITICAL: cfg_in.interstage_critical = csr_wdata[15:0];
            CSR_RESTART_PRESSURE:    cfg_in.restart_pressure    = csr_wdata[15:0];
            CSR_STABLE_DELTA:        cfg_in.stable_delta        = csr_wdata[15:0];
            CSR_STABLE_WINDOW_MS:    cfg_in.stable_window_ms    = csr_wdata[31:0];
            CSR_OVER_TEMP:           cfg_in.over_temp           = csr_wdata[15:0];
            CSR_RESUME_TEMP:         cfg_in.resume_temp         = csr_wdata[15:0];
            CSR_DRIVE_PCT:           cfg_in.drive_pct           = csr_wdata[6:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chamber_critical    <= ChamberCriticalReset;
         cfg_ff.interstage_critical <= InterstageCriticalReset;
         cfg_ff.restart_pressure    <= RestartPressureReset;
         cfg_ff.stable_delta        <= StableDeltaReset;
         cfg_ff.stable_window_ms    <= StableWindowReset;
         cfg_ff.over_temp           <= OverTempReset;
         cfg_ff.resume_temp         <= ResumeTempReset;
         cfg_ff.drive_pct           <= DrivePctReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/pps_in_stage.sv @@
// Input register that holds one sample item until the sequencer takes it.
module pps_in_stage
   import pps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    advance,
   output logic                    sample_valid,
   output sample_type              sample
);

   logic       valid_ff;
   logic       valid_in;
   sample_type sample_ff;
   logic       take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= sample_type'(req_tdata[$bits(sample_type)-1:0]);
      end
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

@@ hw/rtl/pps_core.sv @@
// Phase state and the per-sample decision logic of the sequencer.
module pps_core
   import pps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  sample_type sample,
   input  logic       advance,
   output result_type result
);

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [15:0] last_pressure_ff;
   logic [15:0] last_pressure_in;
   logic [31:0] stable_since_ff;
   logic [31:0] stable_since_in;
   logic        prev_drive_zero_ff;
   logic        prev_drive_zero_in;

   logic        overheat;
   logic        cooled;
   logic [15:0] delta;
   logic [31:0] since_eff;
   logic [31:0] elapsed;
   logic [6:0]  drive;
   logic        fin;

   assign overheat = (sample.temp_first > cfg.over_temp) || (sample.temp_second > cfg.over_temp);
   assign cooled   = (sample.temp_first <= cfg.resume_temp)
                  && (sample.temp_second <= cfg.resume_temp);
   assign delta    = (sample.chamber_pressure >= last_pressure_ff)
                   ? sample.chamber_pressure - last_pressure_ff
                   : last_pressure_ff - sample.chamber_pressure;
   assign since_eff = (stable_since_ff == 32'd0) ? sample.now_ms : stable_since_ff;
   assign elapsed   = sample.now_ms - since_eff;

   always_comb begin
      phase_in         = phase_ff;
      last_pressure_in = last_pressure_ff;
      stable_since_in  = stable_since_ff;
      drive            = 7'd0;
      fin              = 1'b0;
      if (phase_ff == PHASE_FINISHED) begin
         fin = 1'b1;
      end else if (overheat) begin
         if (phase_ff != PHASE_TEMP_HOLD) begin
            phase_in         = PHASE_TEMP_HOLD;
            stable_since_in  = sample.now_ms;
            last_pressure_in = sample.chamber_pressure;
         end
      end else if (phase_ff == PHASE_TEMP_HOLD) begin
         if (cooled) begin
            phase_in         = PHASE_FILLING;
            stable_since_in  = sample.now_ms;
            last_pressure_in = sample.chamber_pressure;
         end
      end else if (sample.safety_stop && prev_drive_zero_ff) begin
         phase_in         = PHASE_WAIT_DROP;
         stable_since_in  = sample.now_ms;
         last_pressure_in = sample.chamber_pressure;
      end else if (phase_ff == PHASE_FILLING) begin
         drive           = (cfg.drive_pct > DrivePctMax) ? DrivePctMax : cfg.drive_pct;
         stable_since_in = since_eff;
         if (delta <= cfg.stable_delta) begin
            if (elapsed >= cfg.stable_window_ms) begin
               phase_in = PHASE_WAIT_DROP;
               drive    = 7'd0;
            end
         end else begin
            stable_since_in = sample.now_ms;
         end
         if ((sample.chamber_pressure >= cfg.chamber_critical)
               || (sample.interstage_pressure >= cfg.interstage_critical)) begin
            phase_in = PHASE_WAIT_DROP;
            drive    = 7'd0;
         end
         last_pressure_in = sample.chamber_pressure;
      end else begin
         if (sample.chamber_pressure <= cfg.restart_pressure) begin
            phase_in = PHASE_FINISHED;
            fin      = 1'b1;
         end
      end
      prev_drive_zero_in = (drive == 7'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PHASE_FILLING;
         last_pressure_ff   <= 16'd0;
         stable_since_ff    <= 32'd0;
         prev_drive_zero_ff <= 1'b1;
      end else if (advance) begin
         phase_ff           <= phase_in;
         last_pressure_ff   <= last_pressure_in;
         stable_since_ff    <= stable_since_in;
         prev_drive_zero_ff <= prev_drive_zero_in;
      end
   end

   always_comb begin
      result.diaphragm_pct = drive;
      result.piston_pct    = drive;
      result.solenoid_open = 1'b0;
      result.finished      = fin;
      result.phase_now     = phase_in;
   end

endmodule

@@ hw/rtl/pps_out_stage.sv @@
// Result register that holds one result item until the consumer takes it.
module pps_out_stage
   import pps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sample_valid,
   input  result_type              result,
   output logic                    advance,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign advance = sample_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(result_type)){1'b0}}, result_ff};

endmodule

@@ hw/rtl/pressurisation_phase_sequencer_top.sv @@
// Flow: an accepted sample item is held in the input register, and its result item is
// registered in the result register as it moves on; a stalled consumer can hold it between.
// Throughput: one sample item per cycle while the consumer takes results; the phase state updates as each item
// moves from the input register into the result register.
// Reset: synchronous and active high; it restores the register defaults, the
// pressurising phase, an unset stable time and a zero previous drive.
module pressurisation_phase_sequencer_top
   import pps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // now_ms, chamber_pressure, interstage_pressure, temp_first, temp_second, safety_stop
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // diaphragm_pct, piston_pct, solenoid_open, finished, phase_now
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type    cfg;
   sample_type sample;
   result_type result;
   logic       sample_valid;
   logic       advance;

   pps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pps_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .advance      (advance),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   pps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .sample  (sample),
      .advance (advance),
      .result  (result)
   );

   pps_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (sample_valid),
      .result       (result),
      .advance      (advance),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

@@ dv/tb_pressurisation_phase_sequencer_top.sv @@
// Self-checking testbench for the pressurisation phase sequencer top level.
`timescale 1ns / 100ps

module tb_pressurisation_phase_sequencer_top;
   import pps_pkg::*;

   localparam int CycleLimit = 600000;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] last_pressure;
      logic [31:0] stable_since;
      logic        prev_drive_zero;
   } sequencer_state_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we;
   logic [CsrAddrWidth-1:0] csr_addr;
   logic [CsrDataWidth-1:0] csr_wdata;

   cfg_type             cfg_mirror;
   sequencer_state_type seq_mirror;
   result_type          expected_results[$];

   logic [31:0] sim_ms;
   int          sim_cp;
   int          req_idle_pct;
   int          rsp_stall_pct;
   int          rsp_holdoff_request;
   int          holdoff_count;
   int          cycle_count = 0;
   int          errors;
   int          samples_sent;
   int          results_checked;
   int          phase_seen[4];

   pressurisation_phase_sequencer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int clip(input int value, input int lo, input int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Works out the result of one sample and moves the mirrored state on.
   function automatic result_type advance_sequencer(inout sequencer_state_type st,
                                                    input sample_type x);
      result_type  res;
      logic [6:0]  drive;
      logic        fin;
      logic [15:0] delta;
      logic        hot;
      logic        cool;
      drive = '0;
      fin   = 1'b0;
      hot   = ($signed(x.temp_first) > $signed(cfg_mirror.over_temp)) ||
              ($signed(x.temp_second) > $signed(cfg_mirror.over_temp));
      cool  = ($signed(x.temp_first) <= $signed(cfg_mirror.resume_temp)) &&
              ($signed(x.temp_second) <= $signed(cfg_mirror.resume_temp));
      if (st.phase == PHASE_FINISHED) begin
         fin = 1'b1;
      end else if (hot) begin
         if (st.phase != PHASE_TEMP_HOLD) begin
            st.phase         = PHASE_TEMP_HOLD;
            st.stable_since  = x.now_ms;
            st.last_pressure = x.chamber_pressure;
         end
      end else if (st.phase == PHASE_TEMP_HOLD) begin
         if (cool) begin
            st.phase         = PHASE_FILLING;
            st.stable_since  = x.now_ms;
            st.last_pressure = x.chamber_pressure;
         end
      end else if (x.safety_stop && st.prev_drive_zero) begin
         st.phase         = PHASE_WAIT_DROP;
         st.stable_since  = x.now_ms;
         st.last_pressure = x.chamber_pressure;
      end else if (st.phase == PHASE_FILLING) begin
         delta = (x.chamber_pressure >= st.last_pressure) ?
                 x.chamber_pressure - st.last_pressure : st.last_pressure - x.chamber_pressure;
         drive = (cfg_mirror.drive_pct > DrivePctMax) ? DrivePctMax : cfg_mirror.drive_pct;
         if (st.stable_since == '0) st.stable_since = x.now_ms;
         if (delta <= cfg_mirror.stable_delta) begin
            if (32'(x.now_ms - st.stable_since) >= cfg_mirror.stable_window_ms) begin
               st.phase = PHASE_WAIT_DROP;
               drive    = '0;
            end
         end else begin
            st.stable_since = x.now_ms;
         end
         if (x.chamber_pressure >= cfg_mirror.chamber_critical ||
             x.interstage_pressure >= cfg_mirror.interstage_critical) begin
            st.phase = PHASE_WAIT_DROP;
            drive    = '0;
         end
         st.last_pressure = x.chamber_pressure;
      end else if (x.chamber_pressure <= cfg_mirror.restart_pressure) begin
         st.phase = PHASE_FINISHED;
         fin      = 1'b1;
      end
      st.prev_drive_zero = (drive == '0);
      res               = '0;
      res.diaphragm_pct = drive;
      res.piston_pct    = drive;
      res.finished      = fin;
      res.phase_now     = st.phase;
      return res;
   endfunction

   function automatic logic [15:0] temp_between(input int lo, input int hi);
      lo = clip(lo, -32768, 32767);
      hi = clip(hi, -32768, 32767);
      if (lo > hi) lo = hi;
      return 16'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic sample_type make_sample(input logic [31:0] now, input int cp, input int ip,
                                              input int t1, input int t2, input logic stop);
      sample_type s;
      s.now_ms              = now;
      s.chamber_pressure    = 16'(cp);
      s.interstage_pressure = 16'(ip);
      s.temp_first          = 16'(t1);
      s.temp_second         = 16'(t2);
      s.safety_stop         = stop;
      return s;
   endfunction

   // Mostly plausible sensor traffic for the current phase, with some pure noise.
   function automatic sample_type shaped_sample();
      sample_type s;
      int over;
      int resume;
      int roll;
      int cp;
      int span;
      int ic;
      int hot_chance;
      over   = $signed(cfg_mirror.over_temp);
      resume = $signed(cfg_mirror.resume_temp);
      ic     = cfg_mirror.interstage_critical;
      s      = '0;
      if ($urandom_range(0, 99) < 15) begin
         s.now_ms              = $urandom;
         s.chamber_pressure    = 16'($urandom);
         s.interstage_pressure = 16'($urandom);
         s.temp_first          = 16'($urandom);
         s.temp_second         = 16'($urandom);
         s.safety_stop         = 1'($urandom_range(0, 1));
         return s;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) s.now_ms = sim_ms + $urandom_range(1, 400);
      else if (roll < 90) s.now_ms = sim_ms + $urandom_range(500, 15000);
      else if (roll < 96) s.now_ms = sim_ms;
      else s.now_ms = $urandom;
      cp   = sim_cp;
      roll = $urandom_range(0, 99);
      case (seq_mirror.phase)
         PHASE_FILLING: begin
            span       = (cfg_mirror.stable_delta < 16'd3000) ? cfg_mirror.stable_delta : 3000;
            hot_chance = 4;
            if (roll < 45)
               cp = int'(seq_mirror.last_pressure) + int'($urandom_range(0, 2 * span)) - span;
            else if (roll < 88)
               cp = int'(seq_mirror.last_pressure) + int'($urandom_range(2, 4000));
            else
               cp = int'(cfg_mirror.chamber_critical) + int'($urandom_range(0, 50));
         end
         PHASE_WAIT_DROP: begin
            hot_chance = 12;
            cp         = cp - int'($urandom_range(0, 3000));
         end
         PHASE_TEMP_HOLD: hot_chance = 35;
         default: begin
            hot_chance = 20;
            cp         = $urandom_range(0, 65535);
         end
      endcase
      s.chamber_pressure = 16'(clip(cp, 0, 65535));
      if (ic == 0 || $urandom_range(0, 99) < 6)
         s.interstage_pressure = 16'($urandom_range(ic, 65535));
      else
         s.interstage_pressure = 16'($urandom_range(0, ic - 1));
      if ($urandom_range(0, 99) < hot_chance) begin
         roll          = $urandom_range(0, 2);
         s.temp_first  = (roll != 1) ? temp_between(over + 1, over + 3000)
                                     : temp_between(resume - 1500, over);
         s.temp_second = (roll != 0) ? temp_between(over + 1, over + 3000)
                                     : temp_between(resume - 1500, over);
      end else if (seq_mirror.phase == PHASE_TEMP_HOLD) begin
         s.temp_first  = temp_between(resume - 2000, resume);
         s.temp_second = temp_between(resume - 2000, resume);
      end else begin
         s.temp_first  = temp_between(resume - 1500, over);
         s.temp_second = temp_between(resume - 1500, over);
      end
      s.safety_stop = ($urandom_range(0, 99) < 4);
      return s;
   endfunction

   // Offers one item; unless allowed, a sample that would end the programme is
   // lifted above the restart level so that the run keeps cycling.
   task automatic send_sample(input sample_type sample_in, input logic allow_finish);
      sample_type          sample;
      sequencer_state_type trial;
      result_type          outcome;
      int                  gap;
      sample = sample_in;
      if (!allow_finish && seq_mirror.phase != PHASE_FINISHED) begin
         trial   = seq_mirror;
         outcome = advance_sequencer(trial, sample);
         if (trial.phase == PHASE_FINISHED)
            sample.chamber_pressure = 16'(int'(cfg_mirror.restart_pressure) + 1 +
               int'($urandom_range(0, 65534 - int'(cfg_mirror.restart_pressure))));
      end
      gap = ($urandom_range(0, 99) < req_idle_pct) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataWidth'(sample);
      do @(posedge clock); while (!req_tready);
      outcome = advance_sequencer(seq_mirror, sample);
      expected_results.push_back(outcome);
      sim_ms = sample.now_ms;
      sim_cp = sample.chamber_pressure;
      samples_sent++;
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic cfg_write(input csr_index_type index, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      case (index)
         CSR_CHAMBER_CRITICAL:    cfg_mirror.chamber_critical    = value[15:0];
         CSR_INTERSTAGE_CRITICAL: cfg_mirror.interstage_critical = value[15:0];
         CSR_RESTART_PRESSURE:    cfg_mirror.restart_pressure    = value[15:0];
         CSR_STABLE_DELTA:        cfg_mirror.stable_delta        = value[15:0];
         CSR_STABLE_WINDOW_MS:    cfg_mirror.stable_window_ms    = value;
         CSR_OVER_TEMP:           cfg_mirror.over_temp           = value[15:0];
         CSR_RESUME_TEMP:         cfg_mirror.resume_temp         = value[15:0];
         CSR_DRIVE_PCT:           cfg_mirror.drive_pct           = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all_settings(input int chamber, input int interstage, input int restart,
                                     input int delta, input logic [31:0] window, input int over,
                                     input int resume, input int drive);
      cfg_write(CSR_CHAMBER_CRITICAL, 32'(chamber));
      cfg_write(CSR_INTERSTAGE_CRITICAL, 32'(interstage));
      cfg_write(CSR_RESTART_PRESSURE, 32'(restart));
      cfg_write(CSR_STABLE_DELTA, 32'(delta));
      cfg_write(CSR_STABLE_WINDOW_MS, window);
      cfg_write(CSR_OVER_TEMP, 32'(over));
      cfg_write(CSR_RESUME_TEMP, 32'(resume));
      cfg_write(CSR_DRIVE_PCT, 32'(drive));
   endtask

   task automatic send_shaped(input int count);
      repeat (count) send_sample(shaped_sample(), 1'b0);
   endtask

   // Overheat then cool down, which lands in the pressurising phase with zero drive.
   task automatic return_to_pressurising(input logic [31:0] now, input int cp);
      send_sample(make_sample(now, cp, 0, 7000, 2500, 1'b0), 1'b0);
      send_sample(make_sample(now + 32'd10, cp, 0, 2500, 2500, 1'b0), 1'b0);
   endtask

   task automatic test_stable_window();
      send_sample(make_sample(32'd0, 0, 0, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'd5, 1, 100, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'd10004, 2, 100, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'd10005, 2, 100, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'd10100, 1001, 0, 2500, 2500, 1'b0), 1'b0);
   endtask

   task automatic test_temperature_hold();
      send_sample(make_sample(32'd10200, 4000, 0, 2500, 6001, 1'b0), 1'b0);
      send_sample(make_sample(32'd10300, 4000, 0, 32767, 32767, 1'b0), 1'b0);
      send_sample(make_sample(32'd10400, 4000, 0, 5001, -32768, 1'b0), 1'b0);
      send_sample(make_sample(32'd10500, 4000, 0, 5000, -32768, 1'b0), 1'b0);
   endtask

   task automatic test_safety_stop();
      send_sample(make_sample(32'd10600, 4500, 0, 2500, 2500, 1'b1), 1'b0);
      return_to_pressurising(32'd10700, 4500);
      send_sample(make_sample(32'd10800, 5000, 0, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'd10900, 5600, 0, 2500, 2500, 1'b1), 1'b0);
   endtask

   task automatic test_critical_limits();
      send_sample(make_sample(32'd11100, 65535, 0, -32768, -32768, 1'b0), 1'b0);
      return_to_pressurising(32'd11200, 3000);
      send_sample(make_sample(32'd11300, 1000, 17000, 0, 0, 1'b0), 1'b0);
      return_to_pressurising(32'd11400, 3000);
      send_sample(make_sample(32'd11500, 19999, 16999, 0, 0, 1'b0), 1'b0);
      send_sample(make_sample(32'd11600, 20000, 65535, 0, 0, 1'b0), 1'b0);
   endtask

   task automatic test_timestamp_wrap();
      return_to_pressurising(32'hFFFF_FEF0, 3000);
      send_sample(make_sample(32'h0000_1000, 3001, 0, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'h0000_2700, 3000, 0, 2500, 2500, 1'b0), 1'b0);
   endtask

   task automatic test_drive_saturation();
      wait_until_idle();
      cfg_write(CSR_DRIVE_PCT, 32'hFFFF_FFFF);
      return_to_pressurising(32'd20000, 3000);
      send_sample(make_sample(32'd20100, 3500, 0, 2500, 2500, 1'b0), 1'b0);
      wait_until_idle();
      cfg_write(CSR_DRIVE_PCT, 32'd0);
      send_sample(make_sample(32'd20200, 4000, 0, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(32'd20300, 4500, 0, 2500, 2500, 1'b1), 1'b0);
      wait_until_idle();
      cfg_write(CSR_DRIVE_PCT, 32'd100);
   endtask

   task automatic test_register_extremes();
      wait_until_idle();
      write_all_settings(65535, 65535, 0, 65535, 32'd0, -32768, -32768, 100);
      send_shaped(30);
      wait_until_idle();
      write_all_settings(0, 0, 0, 0, 32'hFFFF_FFFF, 32767, 32767, 0);
      send_shaped(30);
      wait_until_idle();
      write_all_settings(65535, 65535, 65534, 0, 32'hFFFF_FFFF, 6000, -32768, 127);
      send_shaped(30);
   endtask

   task automatic test_random_programme();
      int over;
      for (int round = 0; round < 6; round++) begin
         wait_until_idle();
         over = int'($urandom_range(0, 9000)) - 1000;
         write_all_settings($urandom_range(15000, 65535), $urandom_range(12000, 65535),
                            $urandom_range(0, 6000), $urandom_range(0, 40),
                            $urandom_range(0, 30000), over,
                            over - int'($urandom_range(0, 3000)), $urandom_range(0, 127));
         req_idle_pct  = (round == 0) ? 0 : $urandom_range(10, 40);
         rsp_stall_pct = (round == 0) ? 0 : $urandom_range(10, 40);
         send_shaped(120);
      end
   endtask

   task automatic test_backpressure();
      req_idle_pct        = 0;
      rsp_stall_pct       = 0;
      rsp_holdoff_request = 120;
      send_shaped(40);
      req_idle_pct  = 25;
      rsp_stall_pct = 25;
   endtask

   task automatic test_completion();
      wait_until_idle();
      write_all_settings(20000, 17000, 1000, 1, 32'd10000, 6000, 5000, 100);
      return_to_pressurising(sim_ms + 32'd100, 3000);
      send_sample(make_sample(sim_ms + 32'd100, 20000, 0, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(sim_ms + 32'd100, 1001, 0, 2500, 2500, 1'b0), 1'b0);
      send_sample(make_sample(sim_ms + 32'd100, 1000, 0, 2500, 2500, 1'b0), 1'b1);
      send_sample(make_sample(sim_ms + 32'd100, 0, 65535, 32767, 32767, 1'b1), 1'b1);
      repeat (6) send_sample(shaped_sample(), 1'b1);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff_request > 0) begin
            rsp_tready    <= 1'b0;
            holdoff_count = 0;
            while (holdoff_count < rsp_holdoff_request) begin
               @(negedge clock);
               holdoff_count++;
            end
            rsp_holdoff_request = 0;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat (idle_length()) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (expected_results.size() == 0) begin
            $display("%0t: result item with none expected, expected nothing, actual %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("diaphragm_pct", want.diaphragm_pct, got.diaphragm_pct);
            check_field("piston_pct", want.piston_pct, got.piston_pct);
            check_field("solenoid_open", want.solenoid_open, got.solenoid_open);
            check_field("finished", want.finished, got.finished);
            check_field("phase_now", want.phase_now, got.phase_now);
            results_checked++;
            phase_seen[got.phase_now]++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t: run stopped after %0d cycles without draining", $time, cycle_count);
         $display("** pressurisation_phase_sequencer_top: FAILED **");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_tvalid          = 1'b0;
      req_tdata           = '0;
      csr_we              = 1'b0;
      csr_addr            = '0;
      csr_wdata           = '0;
      errors              = 0;
      samples_sent        = 0;
      results_checked     = 0;
      phase_seen          = '{default: 0};
      sim_ms              = '0;
      sim_cp              = 0;
      req_idle_pct        = 25;
      rsp_stall_pct       = 25;
      rsp_holdoff_request = 0;
      cfg_mirror = '{chamber_critical:    ChamberCriticalReset,
                     interstage_critical: InterstageCriticalReset,
                     restart_pressure:    RestartPressureReset,
                     stable_delta:        StableDeltaReset,
                     stable_window_ms:    StableWindowReset,
                     over_temp:           OverTempReset,
                     resume_temp:         ResumeTempReset,
                     drive_pct:           DrivePctReset};
      seq_mirror = '{phase: PHASE_FILLING, last_pressure: '0, stable_since: '0,
                     prev_drive_zero: 1'b1};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      test_stable_window();
      test_temperature_hold();
      test_safety_stop();
      test_critical_limits();
      test_timestamp_wrap();
      test_drive_saturation();
      test_register_extremes();
      test_backpressure();
      test_random_programme();
      test_completion();

      wait_until_idle();
      repeat (10) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d result items never arrived", $time, expected_results.size());
         errors++;
      end
      $display("Sent %0d sample items and checked %0d result items, %0d errors.",
               samples_sent, results_checked, errors);
      $display("Results by phase: pressurising %0d, wait %0d, hold %0d, complete %0d.",
               phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
      if (errors == 0) begin
         $display("** pressurisation_phase_sequencer_top: PASSED **");
      end else begin
         $display("** pressurisation_phase_sequencer_top: FAILED **");
      end
      $finish;
   end

endmodule
